// ===== rtl/blocked_thread_hang_monitor_macros.svh =====
// Assertion macros used by the hang monitor back end.
`ifndef BLOCKED_THREAD_HANG_MONITOR_MACROS_SVH
`define BLOCKED_THREAD_HANG_MONITOR_MACROS_SVH

// Condition implies check in the same cycle.
`define BTHM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("hang monitor check failed");

// Condition implies check in the following cycle.
`define BTHM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("hang monitor check failed");

`endif

// ===== rtl/bthm_pkg.sv =====
// Types, codes and sizes shared by the hang monitor modules.
`timescale 1ns / 1ps

package bthm_pkg;

	// Table size and derived widths
	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [30:0] HANG_LIMIT_RESET = 31'd60000;
	localparam logic [5:0]  SWEPT_MAX        = 6'd63;

	// Request kinds
	localparam logic [1:0] KIND_AUDIT_START = 2'd0;
	localparam logic [1:0] KIND_OBSERVE     = 2'd1;
	localparam logic [1:0] KIND_AUDIT_END   = 2'd2;

	// Result status codes
	localparam logic [3:0] ST_NONE      = 4'd0;
	localparam logic [3:0] ST_ADDED     = 4'd1;
	localparam logic [3:0] ST_REFRESHED = 4'd2;
	localparam logic [3:0] ST_WARNING   = 4'd3;
	localparam logic [3:0] ST_HANG      = 4'd4;
	localparam logic [3:0] ST_REMOVED   = 4'd5;
	localparam logic [3:0] ST_FULL      = 4'd6;
	localparam logic [3:0] ST_LATCHED   = 4'd7;
	localparam logic [3:0] ST_REPLACED  = 4'd8;

	// Operation decided by the front end
	typedef enum logic [2:0] {
		OP_AUDIT_START,
		OP_AUDIT_END,
		OP_OBS_BLOCKED,
		OP_OBS_CLEAR,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [21:0] worker_id;
		logic        uninterruptible;
		logic [62:0] block_stamp;
		logic [31:0] now_ms;
	} bthm_in_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] blocked_ms;
		logic        hang_latched;
		logic [5:0]  swept_count;
	} bthm_out_t;

	// Classified request as it travels through the queue
	typedef struct packed {
		op_t         op;
		logic [21:0] worker_id;
		logic [62:0] block_stamp;
		logic [31:0] now_ms;
	} bthm_item_t;

endpackage

// ===== rtl/blocked_thread_hang_monitor.sv =====
// Top level of the blocked worker hang monitor.
//
// Requests enter on in_valid/in_ready with an in_data struct: audit start,
// worker observation or audit end. Each request yields exactly one result on
// out_valid/out_ready (status, blocked time, hang latch, sweep count).
// The hang limit register is written with hang_limit_we/hang_limit_wdata;
// the user writes it only while the block is idle; the block does not enforce this.
// The new limit takes effect at once. A request passes through the front
// register, queue, table lookup and execute before its result is valid.
// The back end sequencer finishes one request before it takes the next:
// id match and table read, then the update, which waits while the result register is full.
// Reset: the table is empty, the hang latch is clear, the limit is 60000 ms;
// no clearing pass is needed, requests are taken right after reset.
// Receiver stall: the result register holds its request, one more sits in
// the lookup stage, two wait in the queue and one in the front register,
// then in_ready drops.
// Once a hang is latched every request returns status latched.
`timescale 1ns / 1ps

module blocked_thread_hang_monitor import bthm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bthm_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bthm_out_t   out_data,
	input  logic        hang_limit_we,
	input  logic [30:0] hang_limit_wdata
);

	logic       push_valid;
	logic       push_ready;
	bthm_item_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	bthm_item_t pop_data;

	bthm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bthm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bthm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.hang_limit_we    (hang_limit_we),
		.hang_limit_wdata (hang_limit_wdata),
		.pop_valid        (pop_valid),
		.pop_ready        (pop_ready),
		.pop_data         (pop_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data)
	);

endmodule

// ===== rtl/bthm_front.sv =====
// Front end: accepts requests and classifies them into table operations.
`timescale 1ns / 1ps

module bthm_front import bthm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bthm_in_t   in_data,
	output logic       push_valid,
	input  logic       push_ready,
	output bthm_item_t push_data
);

	logic       front_valid_q;
	bthm_item_t front_item_s1;
	bthm_item_t item_d;
	logic       accept;

	assign in_ready   = !front_valid_q || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = front_valid_q;
	assign push_data  = front_item_s1;

	// Decode kind and blocked state into an operation
	always_comb begin
		item_d.worker_id   = in_data.worker_id;
		item_d.block_stamp = in_data.block_stamp;
		item_d.now_ms      = in_data.now_ms;
		unique case (in_data.kind)
			KIND_AUDIT_START: item_d.op = OP_AUDIT_START;
			KIND_AUDIT_END:   item_d.op = OP_AUDIT_END;
			KIND_OBSERVE: begin
				if (in_data.uninterruptible && (in_data.block_stamp != 63'd0))
					item_d.op = OP_OBS_BLOCKED;
				else
					item_d.op = OP_OBS_CLEAR;
			end
			default:          item_d.op = OP_IGNORE;
		endcase
	end

	// Holding register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_q <= 1'b0;
		end else if (accept) begin
			front_valid_q <= 1'b1;
		end else if (push_ready) begin
			front_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/bthm_fifo.sv =====
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps

module bthm_fifo import bthm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  bthm_item_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output bthm_item_t pop_data
);

	bthm_item_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/bthm_back.sv =====
// Back end: entry table, match and update sequencer, result register.
`timescale 1ns / 1ps
`include "blocked_thread_hang_monitor_macros.svh"

module bthm_back import bthm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hang_limit_we,
	input  logic [30:0] hang_limit_wdata,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  bthm_item_t  pop_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bthm_out_t   out_data
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EXEC = 2'b10
	} back_state_t;

	back_state_t state_q;

	// Table state
	logic [ENTRIES-1:0] used_q;
	logic [ENTRIES-1:0] stale_q;
	logic               hang_q;
	logic [30:0]        limit_q;
	logic [21:0]        worker_q [ENTRIES];
	logic [31:0]        since_mem [ENTRIES];
	logic [62:0]        stamp_mem [ENTRIES];

	// Lookup stage
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] match_oh;
	logic [ENTRIES-1:0] avail_vec;
	logic [ENTRIES-1:0] avail_oh;
	logic [IDX_W-1:0]   match_idx;
	logic [IDX_W-1:0]   avail_idx;
	logic [CNT_W-1:0]   sweep_cnt;
	logic               pop;

	op_t                op_s1;
	logic [21:0]        worker_s1;
	logic [62:0]        stamp_s1;
	logic [31:0]        now_s1;
	logic               hit_s1;
	logic [IDX_W-1:0]   hit_idx_s1;
	logic               slot_ok_s1;
	logic [IDX_W-1:0]   slot_idx_s1;
	logic [5:0]         swept_s1;
	logic [31:0]        since_s1;
	logic [62:0]        old_stamp_s1;

	// Execute stage
	logic [ENTRIES-1:0] used_d;
	logic [ENTRIES-1:0] stale_d;
	logic               hang_d;
	logic               wr_en;
	logic [31:0]        elapsed;
	bthm_out_t          res;
	logic               out_free;
	logic               exec_fire;
	logic               out_valid_q;
	bthm_out_t          out_data_q;
	logic               out_has_span;
	logic               out_span_ok;

	assign pop       = (state_q == BK_IDLE) && pop_valid;
	assign pop_ready = (state_q == BK_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign exec_fire = (state_q == BK_EXEC) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Parallel id match, lowest free or matching slot, and stale entry count
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = used_q[i] && (worker_q[i] == pop_data.worker_id);
		end
		match_oh  = match_vec & (~match_vec + 1'b1);
		avail_vec = ~used_q | match_oh;
		avail_oh  = avail_vec & (~avail_vec + 1'b1);
		match_idx = '0;
		avail_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_oh[i]) match_idx = match_idx | IDX_W'(i);
			if (avail_oh[i]) avail_idx = avail_idx | IDX_W'(i);
		end
		sweep_cnt = CNT_W'($countones(used_q & stale_q));
	end

	// Lookup registers and table read
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1        <= pop_data.op;
			worker_s1    <= pop_data.worker_id;
			stamp_s1     <= pop_data.block_stamp;
			now_s1       <= pop_data.now_ms;
			hit_s1       <= |match_vec;
			hit_idx_s1   <= match_idx;
			slot_ok_s1   <= |avail_vec;
			slot_idx_s1  <= avail_idx;
			swept_s1     <= (32'(sweep_cnt) > 32'(SWEPT_MAX)) ? SWEPT_MAX : 6'(sweep_cnt);
			since_s1     <= since_mem[match_idx];
			old_stamp_s1 <= stamp_mem[match_idx];
		end
	end

	assign elapsed = now_s1 - since_s1;

	// Execute one operation against the table
	always_comb begin
		used_d  = used_q;
		stale_d = stale_q;
		hang_d  = hang_q;
		wr_en   = 1'b0;
		res     = '0;
		res.status = ST_NONE;
		if (hang_q) begin
			res.status = ST_LATCHED;
		end else begin
			unique case (op_s1)
				OP_AUDIT_START: stale_d = stale_q | used_q;
				OP_AUDIT_END: begin
					used_d          = used_q & ~stale_q;
					stale_d         = '0;
					res.swept_count = swept_s1;
				end
				OP_OBS_BLOCKED: begin
					if (!hit_s1) begin
						if (slot_ok_s1) begin
							used_d[slot_idx_s1]  = 1'b1;
							stale_d[slot_idx_s1] = 1'b0;
							wr_en                = 1'b1;
							res.status           = ST_ADDED;
						end else begin
							res.status = ST_FULL;
						end
					end else if (old_stamp_s1 == stamp_s1) begin
						stale_d[hit_idx_s1] = 1'b0;
						res.blocked_ms      = elapsed;
						if (elapsed > {1'b0, limit_q}) begin
							hang_d     = 1'b1;
							res.status = ST_HANG;
						end else if (elapsed > {2'b00, limit_q[30:1]}) begin
							res.status = ST_WARNING;
						end else begin
							res.status = ST_REFRESHED;
						end
					end else begin
						// free the old entry, then take the lowest free slot
						used_d[hit_idx_s1]   = 1'b0;
						stale_d[hit_idx_s1]  = 1'b0;
						used_d[slot_idx_s1]  = 1'b1;
						stale_d[slot_idx_s1] = 1'b0;
						wr_en                = 1'b1;
						res.status           = ST_REPLACED;
					end
				end
				OP_OBS_CLEAR: begin
					if (hit_s1) begin
						used_d[hit_idx_s1]  = 1'b0;
						stale_d[hit_idx_s1] = 1'b0;
						res.status          = ST_REMOVED;
					end
				end
				default: ;
			endcase
		end
		res.hang_latched = hang_d;
	end

	// Sequencer, table bits, limit and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			used_q      <= '0;
			stale_q     <= '0;
			hang_q      <= 1'b0;
			limit_q     <= HANG_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (hang_limit_we) limit_q <= hang_limit_wdata;
			unique case (state_q)
				BK_IDLE: if (pop) state_q <= BK_EXEC;
				BK_EXEC: if (out_free) state_q <= BK_IDLE;
				default: state_q <= BK_IDLE;
			endcase
			if (exec_fire) begin
				used_q      <= used_d;
				stale_q     <= stale_d;
				hang_q      <= hang_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Entry payload and result data
	always_ff @(posedge clk) begin
		if (exec_fire && wr_en) begin
			worker_q[slot_idx_s1]  <= worker_s1;
			since_mem[slot_idx_s1] <= now_s1;
			stamp_mem[slot_idx_s1] <= stamp_s1;
		end
		if (exec_fire) begin
			out_data_q <= res;
		end
	end

	// Only refresh, warning and hang results carry a blocked time
	assign out_has_span = out_valid_q && (out_data_q.blocked_ms != 32'd0);
	assign out_span_ok  = (out_data_q.status == ST_REFRESHED) ||
		(out_data_q.status == ST_WARNING) || (out_data_q.status == ST_HANG);

	`BTHM_ASSERT_NEXT(a_hang_sticky, clk, arst_n, hang_q, hang_q)
	`BTHM_ASSERT_IMPL(a_stale_only_used, clk, arst_n, 1'b1, (stale_q & ~used_q) == '0)
	`BTHM_ASSERT_NEXT(a_latched_frozen, clk, arst_n, exec_fire && hang_q, $stable(used_q))
	`BTHM_ASSERT_IMPL(a_elapsed_only_refresh, clk, arst_n, out_has_span, out_span_ok)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the blocked worker hang monitor.
`timescale 1ns / 1ps

module tb import bthm_pkg::*; ();

	// Kind code the block does not use; it must be ignored
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 20;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bthm_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bthm_out_t   out_data;
	logic        hang_limit_we = 1'b0;
	logic [30:0] hang_limit_wdata = '0;

	blocked_thread_hang_monitor dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data),
		.hang_limit_we    (hang_limit_we),
		.hang_limit_wdata (hang_limit_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Requests waiting to be driven, results waiting to be seen
	bthm_in_t  pending_reqs [$];
	bthm_out_t exp_results [$];

	// Predicted monitor state
	logic        tbl_used  [ENTRIES];
	logic        tbl_stale [ENTRIES];
	logic [21:0] tbl_worker [ENTRIES];
	logic [31:0] tbl_since [ENTRIES];
	logic [62:0] tbl_stamp [ENTRIES];
	logic        hang_seen = 1'b0;
	logic [30:0] limit_ms = HANG_LIMIT_RESET;

	bit in_taken = 1'b0;
	bit gaps_on = 1'b1;
	bit hold_out_req = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int reqs_taken = 0;
	int status_hits [9];

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_used[i] = 1'b0;
			tbl_stale[i] = 1'b0;
			tbl_worker[i] = '0;
			tbl_since[i] = '0;
			tbl_stamp[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			status_hits[i] = 0;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [62:0] rand_stamp(bit nonzero);
		logic [62:0] s;
		s = 63'({$urandom(), $urandom()});
		if (nonzero && s == '0)
			s = 63'd1;
		return s;
	endfunction

	function automatic void queue_req(logic [1:0] kind, logic [21:0] id, logic sleep,
			logic [62:0] stamp, logic [31:0] now);
		bthm_in_t r;
		r.kind = kind;
		r.worker_id = id;
		r.uninterruptible = sleep;
		r.block_stamp = stamp;
		r.now_ms = now;
		pending_reqs.push_back(r);
	endfunction

	// Request of the given kind with random content in every other field
	function automatic void queue_filler(logic [1:0] kind);
		queue_req(kind, 22'($urandom()), 1'($urandom()), rand_stamp(1'b0), $urandom());
	endfunction

	// Lowest free slot takes the new worker; -1 when the table is full
	function automatic int place_entry(bthm_in_t r);
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_used[i]) begin
				tbl_used[i] = 1'b1;
				tbl_stale[i] = 1'b0;
				tbl_worker[i] = r.worker_id;
				tbl_since[i] = r.now_ms;
				tbl_stamp[i] = r.block_stamp;
				return i;
			end
		end
		return -1;
	endfunction

	// Expected result of one request; updates the predicted table
	function automatic bthm_out_t predict_result(bthm_in_t r);
		bthm_out_t res;
		int hit;
		logic [31:0] span;
		res = '0;
		hit = -1;
		if (hang_seen) begin
			res.status = ST_LATCHED;
		end else if (r.kind == KIND_AUDIT_START) begin
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_used[i])
					tbl_stale[i] = 1'b1;
		end else if (r.kind == KIND_AUDIT_END) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tbl_used[i] && tbl_stale[i]) begin
					tbl_used[i] = 1'b0;
					tbl_stale[i] = 1'b0;
					if (res.swept_count != SWEPT_MAX)
						res.swept_count = res.swept_count + 6'd1;
				end
			end
		end else if (r.kind == KIND_OBSERVE) begin
			// lowest matching index wins
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (tbl_used[i] && tbl_worker[i] == r.worker_id)
					hit = i;
			if (r.uninterruptible && r.block_stamp != '0) begin
				if (hit < 0) begin
					res.status = (place_entry(r) < 0) ? ST_FULL : ST_ADDED;
				end else if (tbl_stamp[hit] == r.block_stamp) begin
					tbl_stale[hit] = 1'b0;
					span = r.now_ms - tbl_since[hit];
					res.blocked_ms = span;
					if (span > {1'b0, limit_ms}) begin
						hang_seen = 1'b1;
						res.status = ST_HANG;
					end else if (span > {2'b0, limit_ms[30:1]}) begin
						res.status = ST_WARNING;
					end else begin
						res.status = ST_REFRESHED;
					end
				end else begin
					// new block of the same worker: free, then re-add
					tbl_used[hit] = 1'b0;
					tbl_stale[hit] = 1'b0;
					void'(place_entry(r));
					res.status = ST_REPLACED;
				end
			end else if (hit >= 0) begin
				tbl_used[hit] = 1'b0;
				tbl_stale[hit] = 1'b0;
				res.status = ST_REMOVED;
			end
		end
		res.hang_latched = hang_seen;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_result(bthm_out_t got);
		bthm_out_t want;
		if (exp_results.size() == 0) begin
			report_mismatch("result with nothing pending", 64'(got), 64'd0);
			return;
		end
		want = exp_results.pop_front();
		if (got.status < 9)
			status_hits[got.status]++;
		if (got.status !== want.status)
			report_mismatch("status", 64'(got.status), 64'(want.status));
		if (got.blocked_ms !== want.blocked_ms)
			report_mismatch("blocked_ms", 64'(got.blocked_ms), 64'(want.blocked_ms));
		if (got.hang_latched !== want.hang_latched)
			report_mismatch("hang_latched", 64'(got.hang_latched), 64'(want.hang_latched));
		if (got.swept_count !== want.swept_count)
			report_mismatch("swept_count", 64'(got.swept_count), 64'(want.swept_count));
	endtask

	// Sample both channels, predict, check, and watch for a stall
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				exp_results.push_back(predict_result(in_data));
				reqs_taken++;
			end
			if (out_valid && out_ready)
				check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, exp_results.size());
				$display("tb failed");
				$finish;
			end
		end
	end

	// Request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_reqs.size() != 0) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1'b1;
				send_gap = gaps_on ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with random stalls and one long hold-off on request
	always @(negedge clk) begin
		if (hold_out_req) begin
			hold_out_req = 1'b0;
			recv_gap = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap--;
		end else begin
			out_ready <= 1'b1;
			if (gaps_on && $urandom_range(0, 3) == 0)
				recv_gap = pick_gap();
		end
	end

	// Block until everything sent has come back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || exp_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_hang_limit(logic [30:0] value);
		@(negedge clk);
		hang_limit_we <= 1'b1;
		hang_limit_wdata <= value;
		@(negedge clk);
		hang_limit_we <= 1'b0;
		limit_ms = value;
	endtask

	// One limit setting: audit rounds over a pool of workers. The ms clock only
	// moves forward within the phase and never further than the limit, so no
	// hang is raised; the table is swept empty at the end.
	task automatic run_phase(logic [30:0] lim, int n_reqs, int pool_n, bit gaps,
			bit long_hold);
		logic [21:0] ids [40];
		logic [62:0] stamps [40];
		logic [31:0] base;
		longint offset;
		longint step;
		logic [31:0] now;
		int made;
		int obs_n;
		int p;
		int r;
		wait_drained();
		set_hang_limit(lim);
		gaps_on = gaps;
		base = $urandom();
		offset = 0;
		step = (longint'(lim) * 3) / n_reqs + 1;
		for (int i = 0; i < pool_n; i++) begin
			ids[i] = 22'($urandom());
			stamps[i] = rand_stamp(1'b1);
		end
		if (long_hold)
			hold_out_req = 1'b1;
		made = 0;
		while (made < n_reqs) begin
			// now and then a round without its audit start or end
			if ($urandom_range(0, 9) != 0)
				queue_filler(KIND_AUDIT_START);
			obs_n = $urandom_range(1, 2 * pool_n);
			for (int k = 0; k < obs_n; k++) begin
				offset += $urandom_range(0, int'(step));
				if (offset > longint'(lim))
					offset = longint'(lim);
				now = base + offset[31:0];
				p = $urandom_range(0, pool_n - 1);
				r = $urandom_range(0, 99);
				if (r < 70) begin
					queue_req(KIND_OBSERVE, ids[p], 1'b1, stamps[p], now);
				end else if (r < 82) begin
					stamps[p] = rand_stamp(1'b1);
					queue_req(KIND_OBSERVE, ids[p], 1'b1, stamps[p], now);
				end else if (r < 91) begin
					queue_req(KIND_OBSERVE, ids[p], 1'b0, rand_stamp(1'b0), now);
				end else begin
					queue_req(KIND_OBSERVE, ids[p], 1'b1, '0, now);
				end
			end
			made += obs_n + 2;
			if ($urandom_range(0, 9) != 0)
				queue_filler(KIND_AUDIT_END);
			if ($urandom_range(0, 19) == 0)
				queue_filler(KIND_UNUSED);
		end
		queue_filler(KIND_AUDIT_START);
		queue_filler(KIND_AUDIT_END);
	endtask

	initial begin
		logic [21:0] last_id;
		logic [62:0] last_stamp;
		logic [31:0] t0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, ms wrap, add, refresh, warning, replace, remove, sweeps (reset limit)
		queue_req(KIND_OBSERVE, 22'h000000, 1'b1, 63'd1, 32'hFFFF_FFF0);
		queue_req(KIND_OBSERVE, 22'h3FFFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF8);
		queue_req(KIND_OBSERVE, 22'h000000, 1'b1, 63'd1, 32'h0000_0010);
		queue_req(KIND_OBSERVE, 22'h3FFFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'h0000_7530);
		queue_req(KIND_OBSERVE, 22'h000000, 1'b1, 63'd2, 32'h0000_7540);
		queue_req(KIND_OBSERVE, 22'h000000, 1'b0, 63'd2, 32'h0000_7540);
		queue_req(KIND_OBSERVE, 22'h000015, 1'b0, 63'd0, 32'h0000_7540);
		queue_req(KIND_OBSERVE, 22'h3FFFFF, 1'b1, 63'd0, 32'h0000_7540);
		queue_req(KIND_UNUSED, 22'h3FFFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(KIND_OBSERVE, 22'h2AAAAA, 1'b1, 63'h2AAA_AAAA_AAAA_AAAA, 32'h0000_7550);
		queue_req(KIND_OBSERVE, 22'h2AAAAA, 1'b1, 63'h2AAA_AAAA_AAAA_AAAA, 32'h0000_7560);
		queue_req(KIND_AUDIT_START, '0, 1'b0, '0, 32'h0000_0000);
		queue_req(KIND_OBSERVE, 22'h155555, 1'b1, 63'h5555_5555_5555_5555, 32'h0000_7570);
		queue_req(KIND_AUDIT_END, 22'h3FFFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(KIND_AUDIT_START, '0, 1'b0, '0, 32'h0000_0000);
		queue_req(KIND_AUDIT_END, '0, 1'b0, '0, 32'h0000_0000);

		// Random phases over several limits, including both extremes and 0, 1
		run_phase(31'd2, 150, 6, 1'b1, 1'b0);
		run_phase(31'h7FFF_FFFF, 200, 40, 1'b1, 1'b1);
		run_phase(31'd0, 80, 4, 1'b0, 1'b0);
		run_phase(31'd1, 80, 8, 1'b1, 1'b0);
		run_phase(31'($urandom_range(2, 5000)), 220, 40, 1'b1, 1'b0);
		run_phase(31'($urandom_range(2, 32'h7FFF_FFFF)), 220, 20, 1'b1, 1'b0);
		run_phase(HANG_LIMIT_RESET, 150, 12, 1'b1, 1'b0);

		// Finale: walk one worker past half the limit, then past the limit
		wait_drained();
		set_hang_limit(31'd100);
		gaps_on = 1'b1;
		t0 = $urandom();
		last_id = 22'($urandom());
		last_stamp = rand_stamp(1'b1);
		queue_req(KIND_OBSERVE, last_id, 1'b1, last_stamp, t0);
		queue_req(KIND_OBSERVE, last_id, 1'b1, last_stamp, t0 + 32'd50);
		queue_req(KIND_OBSERVE, last_id, 1'b1, last_stamp, t0 + 32'd90);
		queue_req(KIND_OBSERVE, last_id, 1'b1, last_stamp, t0 + 32'd101);
		queue_filler(KIND_AUDIT_START);
		queue_req(KIND_OBSERVE, 22'($urandom()), 1'b1, rand_stamp(1'b1), $urandom());
		queue_filler(KIND_AUDIT_END);
		queue_filler(KIND_UNUSED);

		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d requests across limits 0, 1, 2, 100, 60000 and 2^31-1,",
			reqs_taken);
		$display("with %0d adds, %0d refreshes, %0d warnings, %0d hangs, ",
			status_hits[ST_ADDED], status_hits[ST_REFRESHED], status_hits[ST_WARNING],
			status_hits[ST_HANG],
			"%0d removals, %0d full, %0d replaces, %0d latched, %0d no-ops",
			status_hits[ST_REMOVED], status_hits[ST_FULL], status_hits[ST_REPLACED],
			status_hits[ST_LATCHED], status_hits[ST_NONE]);
		if (errors == 0 && exp_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
